// ===== hw/rtl/psrf_pkg.sv =====
`default_nettype none

package psrf_pkg;

    // line store and pixel geometry
    localparam int MAX_WIDTH  = 64;
    localparam int PIXEL_BITS = 8;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = 16;

    // configuration register fields
    localparam int THRESH_BITS    = 8;
    localparam int WIDTH_BITS     = 7;
    localparam int HEIGHT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int MIN_DIM        = 2;

    // reset values of the configuration registers
    localparam int RST_THRESH = 1;
    localparam int RST_WIDTH  = 30;
    localparam int RST_HEIGHT = 20;

    // column arithmetic must hold both the width field and column + 2
    localparam int W_BITS = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;

    // neighbour sum and the reciprocal used for the mean of three
    localparam int SUM_BITS   = PIXEL_BITS + 2;
    localparam int DIV3_SHIFT = SUM_BITS + 1;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int PROD_BITS  = 2 * SUM_BITS;
    localparam int CMP_BITS   = (PIXEL_BITS > THRESH_BITS) ? PIXEL_BITS : THRESH_BITS;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;
    localparam int PUSH_MAX    = 3;
    localparam int PUSH_BITS   = $clog2(PUSH_MAX + 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_index;

    // which of the four neighbours exist
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr_mask;

    // one released pixel
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   column;
        logic                  done;
    } t_result;

    // result queue status toward the top level
    typedef struct packed {
        logic valid;
        logic room;
    } t_queue_status;

    // absolute difference of two pixels is above the threshold
    function automatic logic exceeds(
        input logic [PIXEL_BITS-1:0]  a,
        input logic [PIXEL_BITS-1:0]  b,
        input logic [THRESH_BITS-1:0] thr
    );
        logic [PIXEL_BITS-1:0] diff;
        diff = (a > b) ? a - b : b - a;
        return CMP_BITS'(diff) > CMP_BITS'(thr);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/psrf_decide.sv =====
`default_nettype none

module psrf_decide (
    input  wire logic [psrf_pkg::PIXEL_BITS-1:0]  i_center,
    input  wire logic [psrf_pkg::PIXEL_BITS-1:0]  i_up,
    input  wire logic [psrf_pkg::PIXEL_BITS-1:0]  i_down,
    input  wire logic [psrf_pkg::PIXEL_BITS-1:0]  i_left,
    input  wire logic [psrf_pkg::PIXEL_BITS-1:0]  i_right,
    input  wire psrf_pkg::t_nbr_mask              i_has,
    input  wire logic [psrf_pkg::THRESH_BITS-1:0] i_threshold,
    output logic [psrf_pkg::PIXEL_BITS-1:0]       o_pixel
);

    logic                             spike;
    logic [2:0]                       count;
    logic [psrf_pkg::SUM_BITS-1:0]    sum;
    logic [psrf_pkg::PROD_BITS-1:0]   prod;
    logic [psrf_pkg::SUM_BITS-1:0]    mean;

    // spike test: every present neighbour differs by more than the threshold
    always_comb begin
        spike = (!i_has.up    || psrf_pkg::exceeds(i_center, i_up, i_threshold))
             && (!i_has.down  || psrf_pkg::exceeds(i_center, i_down, i_threshold))
             && (!i_has.left  || psrf_pkg::exceeds(i_center, i_left, i_threshold))
             && (!i_has.right || psrf_pkg::exceeds(i_center, i_right, i_threshold));
    end

    // neighbour count and sum
    always_comb begin
        count = 3'(i_has.up) + 3'(i_has.down) + 3'(i_has.left) + 3'(i_has.right);
        sum   = (i_has.up    ? psrf_pkg::SUM_BITS'(i_up)    : '0)
              + (i_has.down  ? psrf_pkg::SUM_BITS'(i_down)  : '0)
              + (i_has.left  ? psrf_pkg::SUM_BITS'(i_left)  : '0)
              + (i_has.right ? psrf_pkg::SUM_BITS'(i_right) : '0);
        prod  = psrf_pkg::PROD_BITS'(sum) * psrf_pkg::PROD_BITS'(psrf_pkg::DIV3_MUL);
    end

    // truncated mean, divide by three through the reciprocal
    always_comb begin
        unique case (count)
            3'd4:    mean = sum >> 2;
            3'd3:    mean = psrf_pkg::SUM_BITS'(prod >> psrf_pkg::DIV3_SHIFT);
            3'd2:    mean = sum >> 1;
            3'd1:    mean = sum;
            default: mean = psrf_pkg::SUM_BITS'(i_center);
        endcase
    end

    assign o_pixel = (spike && count != 3'd0) ? psrf_pkg::PIXEL_BITS'(mean) : i_center;

endmodule

`default_nettype wire

// ===== hw/rtl/psrf_queue.sv =====
`default_nettype none

module psrf_queue (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [psrf_pkg::PUSH_BITS-1:0]        i_push_count,
    input  wire psrf_pkg::t_result [psrf_pkg::PUSH_MAX-1:0] i_push_data,
    input  wire logic                                  i_pop_stall,
    output psrf_pkg::t_queue_status                    o_status,
    output psrf_pkg::t_result                          o_head
);

    logic [psrf_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [psrf_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [psrf_pkg::QCNT_BITS-1:0] r_count;
    psrf_pkg::t_result              r_slot [psrf_pkg::QUEUE_DEPTH];
    logic                           pop;

    // head transfer and free space for a full burst of results
    assign o_status.valid = (r_count != '0);
    assign o_status.room  = (r_count <= psrf_pkg::QCNT_BITS'(psrf_pkg::QUEUE_DEPTH
                                                            - psrf_pkg::PUSH_MAX));
    assign pop            = o_status.valid && !i_pop_stall;
    assign o_head         = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + psrf_pkg::QPTR_BITS'(i_push_count);
            r_rd_ptr <= r_rd_ptr + psrf_pkg::QPTR_BITS'(pop);
            r_count  <= r_count + psrf_pkg::QCNT_BITS'(i_push_count)
                                - psrf_pkg::QCNT_BITS'(pop);
        end
    end

    // burst write of up to three results in order
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < psrf_pkg::PUSH_MAX; k++) begin
            if (psrf_pkg::PUSH_BITS'(k) < i_push_count) begin
                r_slot[r_wr_ptr + psrf_pkg::QPTR_BITS'(k)] <= i_push_data[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_spike_removal_filter_unit.sv =====
`default_nettype none

// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ------------------------------------------
// in        input      i_in_valid / o_in_stall    i_pixel_in
// out       output     o_out_valid / i_out_stall  o_pixel_out o_out_row o_out_column
//                                                 o_frame_done
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// one pixel per cycle while o_in_stall is low; the pixels a transfer releases are
// decided in the cycle of that transfer and go to a four-entry result queue with a
// single output port; the last row releases two results per pixel after column 0
// (three on the final pixel), so the queue's output port holds back the input there
// synchronous active-low reset clears counters, queue and registers (threshold 1,
// width 30, height 20); the two line stores are not cleared and need no pass
// o_in_stall rises while the queue has fewer than three free entries

module pixel_spike_removal_filter_unit (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_stall,
    input  wire logic [psrf_pkg::PIXEL_BITS-1:0]         i_pixel_in,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_stall,
    output logic [psrf_pkg::PIXEL_BITS-1:0]              o_pixel_out,
    output logic [psrf_pkg::ROW_BITS-1:0]                o_out_row,
    output logic [psrf_pkg::COL_BITS-1:0]                o_out_column,
    output logic                                         o_frame_done,
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [psrf_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  wire logic [psrf_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int PB = psrf_pkg::PIXEL_BITS;
    localparam int CB = psrf_pkg::COL_BITS;
    localparam int RB = psrf_pkg::ROW_BITS;
    localparam int WB = psrf_pkg::W_BITS;

    // configuration and position
    logic [psrf_pkg::THRESH_BITS-1:0] r_cfg_thresh;
    logic [psrf_pkg::WIDTH_BITS-1:0]  r_cfg_width;
    logic [psrf_pkg::HEIGHT_BITS-1:0] r_cfg_height;
    logic [RB-1:0]                    r_row;
    logic [CB-1:0]                    r_col;

    // line stores
    logic [PB-1:0] r_orig_mem [psrf_pkg::MAX_WIDTH];
    logic [PB-1:0] r_filt_mem [psrf_pkg::MAX_WIDTH];

    // prefetched neighbours and the filtered values left behind
    logic [PB-1:0] r_orig_center;
    logic [PB-1:0] r_orig_right;
    logic [PB-1:0] r_filt_up;
    logic [PB-1:0] r_left;
    logic [PB-1:0] r_u_prev;
    logic [PB-1:0] r_prev_pixel;

    logic                             in_accept;
    logic                             cfg_wr;
    logic [WB-1:0]                    w_eff;
    logic [RB-1:0]                    h_eff;
    logic [WB-1:0]                    col_ext;
    logic [WB-1:0]                    col_p2;
    logic                             last_col;
    logic                             last_row;
    logic                             row_gt0;
    logic [CB-1:0]                    center_addr;
    logic [CB-1:0]                    right_addr;
    psrf_pkg::t_nbr_mask              has_v;
    psrf_pkg::t_nbr_mask              has_u;
    logic [PB-1:0]                    pix_v;
    logic [PB-1:0]                    pix_u;
    logic [PB-1:0]                    pix_f;
    logic [PB:0]                      pair_sum;
    logic [psrf_pkg::PUSH_BITS-1:0]   push_count;
    psrf_pkg::t_result [psrf_pkg::PUSH_MAX-1:0] push_data;
    psrf_pkg::t_queue_status          q_status;
    psrf_pkg::t_result                q_head;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = !q_status.room;
    assign in_accept   = i_in_valid && !o_in_stall;

    // geometry in use
    always_comb begin
        if (WB'(r_cfg_width) < WB'(psrf_pkg::MIN_DIM)) begin
            w_eff = WB'(psrf_pkg::MIN_DIM);
        end else if (WB'(r_cfg_width) > WB'(psrf_pkg::MAX_WIDTH)) begin
            w_eff = WB'(psrf_pkg::MAX_WIDTH);
        end else begin
            w_eff = WB'(r_cfg_width);
        end
        h_eff = (r_cfg_height < RB'(psrf_pkg::MIN_DIM)) ? RB'(psrf_pkg::MIN_DIM)
                                                          : r_cfg_height;
    end

    // position flags and prefetch addresses for the next pixel
    always_comb begin
        col_ext     = WB'(r_col);
        col_p2      = col_ext + WB'(2);
        last_col    = (col_ext == w_eff - WB'(1));
        last_row    = (r_row == h_eff - RB'(1));
        row_gt0     = (r_row != '0);
        center_addr = last_col ? '0 : CB'(col_ext + WB'(1));
        right_addr  = (col_p2 < w_eff) ? CB'(col_p2) : CB'(col_p2 - w_eff);
    end

    // release of the pixel above the arriving one
    assign has_v = '{up: (r_row > RB'(1)), down: 1'b1, left: (r_col != '0), right: !last_col};

    psrf_decide u_decide_above (
        .i_center    (r_orig_center),
        .i_up        (r_filt_up),
        .i_down      (i_pixel_in),
        .i_left      (r_left),
        .i_right     (r_orig_right),
        .i_has       (has_v),
        .i_threshold (r_cfg_thresh),
        .o_pixel     (pix_v)
    );

    // last row: release of the pixel left of the arriving one
    assign has_u = '{up: 1'b1, down: 1'b0, left: (r_col > CB'(1)), right: 1'b1};

    psrf_decide u_decide_left (
        .i_center    (r_prev_pixel),
        .i_up        (r_left),
        .i_down      (i_pixel_in),
        .i_left      (r_u_prev),
        .i_right     (i_pixel_in),
        .i_has       (has_u),
        .i_threshold (r_cfg_thresh),
        .o_pixel     (pix_u)
    );

    // final pixel of the frame: up and left neighbours only
    always_comb begin
        pair_sum = (PB+1)'(pix_v) + (PB+1)'(pix_u);
        if (psrf_pkg::exceeds(i_pixel_in, pix_v, r_cfg_thresh)
            && psrf_pkg::exceeds(i_pixel_in, pix_u, r_cfg_thresh)) begin
            pix_f = PB'(pair_sum >> 1);
        end else begin
            pix_f = i_pixel_in;
        end
    end

    // results of this transfer, always a prefix in release order
    always_comb begin
        push_data[0] = '{pixel: pix_v, row: r_row - RB'(1), column: r_col, done: 1'b0};
        push_data[1] = '{pixel: pix_u, row: r_row, column: r_col - CB'(1), done: 1'b0};
        push_data[2] = '{pixel: pix_f, row: r_row, column: r_col, done: 1'b1};
        push_count   = '0;
        if (in_accept) begin
            push_count = psrf_pkg::PUSH_BITS'(row_gt0)
                       + psrf_pkg::PUSH_BITS'(last_row && r_col != '0)
                       + psrf_pkg::PUSH_BITS'(last_row && last_col);
        end
    end

    psrf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_push_data  (push_data),
        .i_pop_stall  (i_out_stall),
        .o_status     (q_status),
        .o_head       (q_head)
    );

    assign o_out_valid  = q_status.valid;
    assign o_pixel_out  = q_head.pixel;
    assign o_out_row    = q_head.row;
    assign o_out_column = q_head.column;
    assign o_frame_done = q_head.done;

    // configuration registers and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thresh <= psrf_pkg::THRESH_BITS'(psrf_pkg::RST_THRESH);
            r_cfg_width  <= psrf_pkg::WIDTH_BITS'(psrf_pkg::RST_WIDTH);
            r_cfg_height <= psrf_pkg::HEIGHT_BITS'(psrf_pkg::RST_HEIGHT);
            r_row        <= '0;
            r_col        <= '0;
        end else if (cfg_wr) begin
            unique case (psrf_pkg::t_cfg_index'(i_cfg_index))
                psrf_pkg::CFG_THRESHOLD: begin
                    r_cfg_thresh <= i_cfg_data[psrf_pkg::THRESH_BITS-1:0];
                end
                psrf_pkg::CFG_WIDTH: begin
                    r_cfg_width <= i_cfg_data[psrf_pkg::WIDTH_BITS-1:0];
                    r_row       <= '0;
                    r_col       <= '0;
                end
                psrf_pkg::CFG_HEIGHT: begin
                    r_cfg_height <= i_cfg_data[psrf_pkg::HEIGHT_BITS-1:0];
                    r_row        <= '0;
                    r_col        <= '0;
                end
                default: begin
                    r_cfg_thresh <= r_cfg_thresh;
                end
            endcase
        end else if (in_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RB'(1);
            end else begin
                r_col <= r_col + CB'(1);
            end
        end
    end

    // original row store with one-ahead prefetch, bypass for narrow frames
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_orig_mem[r_col] <= i_pixel_in;
            r_orig_center     <= r_orig_mem[center_addr];
            r_orig_right      <= (right_addr == r_col) ? i_pixel_in : r_orig_mem[right_addr];
        end
    end

    // filtered row store, read one column ahead
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (row_gt0) begin
                r_filt_mem[r_col] <= pix_v;
            end
            r_filt_up <= r_filt_mem[center_addr];
        end
    end

    // filtered left values and the previous original pixel
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_left       <= pix_v;
            r_u_prev     <= pix_u;
            r_prev_pixel <= i_pixel_in;
        end
    end

    // checks
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WB'(r_col) < w_eff)
        else $error("column position outside frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < h_eff)
        else $error("row position outside frame height");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !cfg_wr && last_row && last_col |=> r_row == '0 && r_col == '0)
        else $error("position did not return to frame start");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_count != '0 |-> q_status.room)
        else $error("results pushed without queue room");

endmodule

`default_nettype wire
